// File: sv/kfc_pkg.sv
`timescale 1ns / 1ps

package kfc_pkg;

  localparam int MaxKmer    = 8;
  localparam int KeyBits    = 2 * MaxKmer;
  localparam int TableDepth = 1 << KeyBits;
  localparam int LenBits    = 4;
  localparam int CountBits  = 16;

  localparam logic [LenBits-1:0]   ResetLen    = LenBits'(MaxKmer);
  localparam logic [CountBits-1:0] CountMax    = '1;
  localparam logic [2:0]           UnknownBase = 3'd4;

  localparam logic [0:0] OpPush = 1'b0;
  localparam logic [0:0] OpRead = 1'b1;

  typedef struct packed {
    logic [0:0]  opcode;
    logic [2:0]  base;
    logic        last_of_read;
    logic [15:0] table_index;
  } cmd_t;

  typedef struct packed {
    logic [15:0] count_value;
    logic        counted;
  } res_t;

  // Lookup issued by the k-mer tracker toward the counter update stage
  typedef struct packed {
    logic               rd;
    logic               inc;
    logic [KeyBits-1:0] addr;
  } req_t;

endpackage

// File: sv/kmer_frequency_counter.sv
`timescale 1ns / 1ps
// An accepted word passes through pend_q and then done_q; its result appears on res_o with done_o.
// A new word is taken only once busy drops; busy stays high after each accepted word
// while pend_q is set, as the counter read returns and the new count is written.
// Reset: after rst_ni the counter memory is cleared one entry a cycle, all
// 65536 entries with busy high; kmer_len returns to 8. Results cannot stall.
module kmer_frequency_counter (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  kfc_pkg::cmd_t               cmd_i,
  output logic                        done_o,
  output kfc_pkg::res_t               res_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [kfc_pkg::LenBits-1:0] cfg_data_i
);
  import kfc_pkg::*;

  logic                 accept;
  logic                 pend;
  req_t                 req;
  logic                 upd_we;
  logic [KeyBits-1:0]   upd_waddr;
  logic [CountBits-1:0] upd_wdata;
  logic                 ram_we;
  logic [KeyBits-1:0]   ram_waddr;
  logic [CountBits-1:0] ram_wdata;
  logic [CountBits-1:0] ram_rdata;
  logic                 clr_q;
  logic [KeyBits-1:0]   clr_addr_q;

  assign busy        = clr_q || pend;
  assign accept      = start && !busy;
  assign cfg_ready_o = !pend;

  // clearing sweep after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + KeyBits'(1);
      if (&clr_addr_q) begin
        clr_q <= 1'b0;
      end
    end
  end

  assign ram_we    = clr_q || upd_we;
  assign ram_waddr = clr_q ? clr_addr_q : upd_waddr;
  assign ram_wdata = clr_q ? '0 : upd_wdata;

  kfc_kmer_track u_track (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .cmd_i      (cmd_i),
    .req_o      (req)
  );

  kfc_ram #(
    .Width (CountBits),
    .Depth (TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (req.addr),
    .rdata_o (ram_rdata)
  );

  kfc_count_upd u_upd (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .req_i    (req),
    .rdata_i  (ram_rdata),
    .we_o     (upd_we),
    .waddr_o  (upd_waddr),
    .wdata_o  (upd_wdata),
    .pend_o   (pend),
    .done_o   (done_o),
    .res_o    (res_o)
  );

`ifndef SYNTHESIS
  a_done_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 2))
    else $error("result word without an accepted word");
  a_no_result_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !done_o && !pend)
    else $error("work started during the clearing sweep");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("new word taken during a read-modify-write");
`endif

endmodule

// File: sv/kfc_ram.sv
`timescale 1ns / 1ps

module kfc_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/kfc_kmer_track.sv
`timescale 1ns / 1ps

module kfc_kmer_track (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [kfc_pkg::LenBits-1:0] cfg_data_i,
  input  logic                    accept_i,
  input  kfc_pkg::cmd_t           cmd_i,
  output kfc_pkg::req_t           req_o
);
  import kfc_pkg::*;

  logic [LenBits-1:0] kmer_len_q;
  logic [KeyBits-1:0] key_q, key_d;
  logic [LenBits-1:0] seen_q, seen_d;
  logic               stop_q, stop_d;
  logic [LenBits-1:0] k_len;
  logic [KeyBits-1:0] key_mask;
  logic [KeyBits-1:0] key_shift;
  logic [LenBits-1:0] seen_inc;
  logic               is_read;

  always_comb begin
    if (kmer_len_q == '0) begin
      k_len = LenBits'(1);
    end else if (kmer_len_q > LenBits'(MaxKmer)) begin
      k_len = LenBits'(MaxKmer);
    end else begin
      k_len = kmer_len_q;
    end
    for (int i = 0; i < KeyBits; i++) begin
      key_mask[i] = (i < 2 * int'(k_len));
    end
  end

  assign is_read   = (cmd_i.opcode == OpRead);
  assign key_shift = {key_q[KeyBits-3:0], cmd_i.base[1:0]};
  assign seen_inc  = (seen_q < LenBits'(MaxKmer)) ? seen_q + LenBits'(1) : seen_q;

  always_comb begin
    key_d      = key_q;
    seen_d     = seen_q;
    stop_d     = stop_q;
    req_o.rd   = is_read;
    req_o.inc  = 1'b0;
    req_o.addr = KeyBits'(cmd_i.table_index);
    if (!is_read) begin
      if (cmd_i.base >= UnknownBase) begin
        stop_d = 1'b1;
      end else if (!stop_q) begin
        key_d      = key_shift;
        seen_d     = seen_inc;
        req_o.inc  = (seen_inc >= k_len);
        req_o.addr = key_shift & key_mask;
      end
      // end of read: drop the rolling state
      if (cmd_i.last_of_read) begin
        key_d  = '0;
        seen_d = '0;
        stop_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kmer_len_q <= ResetLen;
      key_q      <= '0;
      seen_q     <= '0;
      stop_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        kmer_len_q <= cfg_data_i;
      end
      if (accept_i) begin
        key_q  <= key_d;
        seen_q <= seen_d;
        stop_q <= stop_d;
      end
    end
  end

`ifndef SYNTHESIS
  a_seen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q <= LenBits'(MaxKmer))
    else $error("bases seen beyond the longest k-mer");
  a_no_inc_when_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && stop_q |-> !req_o.inc)
    else $error("count requested in a stopped read");
  a_read_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && !is_read && cmd_i.last_of_read |=> seen_q == '0 && !stop_q)
    else $error("read state kept past end of read");
`endif

endmodule

// File: sv/kfc_count_upd.sv
`timescale 1ns / 1ps

module kfc_count_upd (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  kfc_pkg::req_t                  req_i,
  input  logic [kfc_pkg::CountBits-1:0]  rdata_i,
  output logic                           we_o,
  output logic [kfc_pkg::KeyBits-1:0]    waddr_o,
  output logic [kfc_pkg::CountBits-1:0]  wdata_o,
  output logic                           pend_o,
  output logic                           done_o,
  output kfc_pkg::res_t                  res_o
);
  import kfc_pkg::*;

  logic               pend_q;
  logic               rd_q;
  logic               inc_q;
  logic [KeyBits-1:0] addr_q;
  logic               done_q;
  res_t               res_q, res_d;
  logic [CountBits-1:0] cnt_next;

  // saturate rather than wrap
  assign cnt_next = (rdata_i == CountMax) ? rdata_i : rdata_i + CountBits'(1);

  always_comb begin
    res_d = '0;
    if (inc_q) begin
      res_d.count_value = cnt_next;
      res_d.counted     = 1'b1;
    end else if (rd_q) begin
      res_d.count_value = rdata_i;
    end
  end

  assign we_o    = pend_q && inc_q;
  assign waddr_o = addr_q;
  assign wdata_o = cnt_next;
  assign pend_o  = pend_q;
  assign done_o  = done_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      pend_q <= accept_i;
      done_q <= pend_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      rd_q   <= req_i.rd;
      inc_q  <= req_i.inc;
      addr_q <= req_i.addr;
    end
    if (pend_q) begin
      res_q <= res_d;
    end
  end

`ifndef SYNTHESIS
  a_counted_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && res_q.counted |-> res_q.count_value != '0)
    else $error("counted word carries a zero count");
  a_write_only_on_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we_o |-> pend_q && !rd_q)
    else $error("counter written on a read");
  a_done_follows_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |=> done_q)
    else $error("result word lost");
`endif

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import kfc_pkg::*;

  localparam logic [2:0] BaseA    = 3'd0;
  localparam logic [2:0] BaseC    = 3'd1;
  localparam logic [2:0] BaseG    = 3'd2;
  localparam logic [2:0] BaseT    = 3'd3;
  localparam logic [2:0] BaseJunk = 3'd7;

  localparam int RandItems    = 1650;
  localparam int CalmItems    = 300;
  localparam int RepeatPushes = 120;
  localparam int SettleCycles = 6;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               start       = 1'b0;
  logic               busy;
  cmd_t               cmd_i       = '0;
  logic               done_o;
  res_t               res_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [LenBits-1:0] cfg_data_i  = '0;

  // Shadow of the counter table and the read tracker
  bit [CountBits-1:0] count_mem [TableDepth];
  bit [KeyBits-1:0]   roll_key;
  int                 n_bases;
  bit                 read_halted;
  bit [LenBits-1:0]   len_reg;
  bit [KeyBits-1:0]   recent_key;
  res_t               pending_counts [$];

  int err_cnt      = 0;
  int n_cmds       = 0;
  int n_lookups    = 0;
  int n_hits       = 0;
  int n_len_writes = 0;
  bit gaps_on      = 1'b1;

  always #2 clk_i = ~clk_i;

  kmer_frequency_counter i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .cmd_i       (cmd_i),
    .done_o      (done_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  function automatic res_t count_kmer(cmd_t c);
    res_t             r;
    int               k;
    bit [KeyBits-1:0] key;
    r = '0;
    if (c.opcode == OpRead) begin
      r.count_value = count_mem[c.table_index[KeyBits-1:0]];
    end else begin
      if (c.base >= UnknownBase) begin
        read_halted = 1'b1;
      end else if (!read_halted) begin
        k = (len_reg == 0) ? 1 : (len_reg > MaxKmer) ? MaxKmer : int'(len_reg);
        roll_key = {roll_key[KeyBits-3:0], c.base[1:0]};
        if (n_bases < MaxKmer) n_bases++;
        if (n_bases >= k) begin
          key = roll_key & KeyBits'((1 << (2 * k)) - 1);
          if (count_mem[key] != CountMax) count_mem[key]++;
          r.count_value = count_mem[key];
          r.counted     = 1'b1;
          recent_key    = key;
        end
      end
      if (c.last_of_read) begin
        roll_key    = '0;
        n_bases     = 0;
        read_halted = 1'b0;
      end
    end
    return r;
  endfunction

  task automatic issue_cmd(logic [0:0] op, logic [2:0] b, logic last, logic [15:0] idx);
    cmd_t c;
    c.opcode       = op;
    c.base         = b;
    c.last_of_read = last;
    c.table_index  = idx;
    start <= 1'b1;
    cmd_i <= c;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_counts.push_back(count_kmer(c));
    n_cmds++;
    if (op == OpRead) n_lookups++;
  endtask

  task automatic sender_gap(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic maybe_gap();
    if (gaps_on && $urandom_range(0, 3) == 0) sender_gap($urandom_range(1, 13));
  endtask

  // Hold off until every issued word has come back
  task automatic drain_counts();
    start <= 1'b0;
    while (pending_counts.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_kmer_len(logic [LenBits-1:0] v);
    drain_counts();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    len_reg = v;
    n_len_writes++;
  endtask

  task automatic lookup_random();
    logic [15:0] idx;
    case ($urandom_range(0, 2))
      0:       idx = recent_key;
      1:       idx = 16'($urandom_range(0, 255));
      default: idx = 16'($urandom());
    endcase
    issue_cmd(OpRead, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)), idx);
  endtask

  always @(posedge clk_i) begin : check_counts
    res_t want;
    if (rst_ni && done_o) begin
      if (pending_counts.size() == 0) begin
        err_cnt++;
        $error("unexpected result: count_value %0d counted %0b",
               res_o.count_value, res_o.counted);
      end else begin
        want = pending_counts.pop_front();
        if (res_o.count_value !== want.count_value) begin
          err_cnt++;
          $error("count_value: expected %0d, got %0d", want.count_value, res_o.count_value);
        end
        if (res_o.counted !== want.counted) begin
          err_cnt++;
          $error("counted: expected %0b, got %0b", want.counted, res_o.counted);
        end
        if (want.counted) n_hits++;
      end
    end
  end

  task automatic test_reset_state();
    issue_cmd(OpRead, BaseJunk, 1'b1, 16'hFFFF);
  endtask

  task automatic test_short_reads();
    write_kmer_len(4'd3);
    issue_cmd(OpPush, BaseA, 1'b0, 16'h0000);
    issue_cmd(OpPush, BaseC, 1'b1, 16'hFFFF);
    issue_cmd(OpPush, BaseA, 1'b0, 16'h0000);
    issue_cmd(OpPush, BaseC, 1'b0, 16'h0000);
    issue_cmd(OpPush, BaseG, 1'b1, 16'h0000);
    issue_cmd(OpRead, BaseA, 1'b0, 16'd6);
  endtask

  task automatic test_len_extremes();
    // zero acts as one base
    write_kmer_len(4'd0);
    issue_cmd(OpPush, BaseG, 1'b0, 16'h0000);
    issue_cmd(OpPush, BaseT, 1'b1, 16'h0000);
    // above the maximum acts as the maximum
    write_kmer_len(4'd15);
    for (int i = 0; i < MaxKmer; i++) issue_cmd(OpPush, BaseT, i == MaxKmer - 1, 16'hFFFF);
  endtask

  task automatic test_unknown_base();
    write_kmer_len(4'd2);
    issue_cmd(OpPush, BaseA, 1'b0, 16'h0000);
    issue_cmd(OpPush, BaseC, 1'b0, 16'h0000);
    issue_cmd(OpPush, UnknownBase, 1'b0, 16'h0000);
    issue_cmd(OpPush, BaseG, 1'b1, 16'h0000);
    issue_cmd(OpPush, BaseJunk, 1'b1, 16'h0000);
  endtask

  task automatic test_len_change();
    write_kmer_len(4'd4);
    issue_cmd(OpPush, BaseA, 1'b0, 16'h0000);
    issue_cmd(OpPush, BaseC, 1'b0, 16'h0000);
    issue_cmd(OpPush, BaseG, 1'b0, 16'h0000);
    issue_cmd(OpPush, BaseT, 1'b0, 16'h0000);
    write_kmer_len(4'd2);
    // a lookup carrying last_of_read must not end the open read
    issue_cmd(OpRead, BaseJunk, 1'b1, 16'h001B);
    issue_cmd(OpPush, BaseA, 1'b1, 16'h0000);
  endtask

  task automatic test_repeat_key();
    write_kmer_len(4'd1);
    for (int i = 0; i < RepeatPushes; i++) begin
      issue_cmd(OpPush, BaseT, i == RepeatPushes - 1, 16'h0000);
    end
    issue_cmd(OpRead, BaseA, 1'b0, 16'd3);
  endtask

  task automatic test_random_traffic(int n_items);
    int         sent;
    int         kind;
    int         rlen;
    int         burst;
    logic [2:0] b;
    sent = 0;
    while (sent < n_items) begin
      gaps_on = (sent < n_items - CalmItems);
      kind = $urandom_range(0, 19);
      if (kind == 0 && gaps_on) begin
        write_kmer_len(LenBits'($urandom_range(0, 15)));
      end else if (kind <= 13) begin
        rlen = $urandom_range(1, 20);
        for (int i = 0; i < rlen; i++) begin
          if ($urandom_range(0, 5) == 0) begin
            maybe_gap();
            lookup_random();
            sent++;
          end
          b = ($urandom_range(0, 39) == 0) ? 3'($urandom_range(4, 7))
                                           : 3'($urandom_range(0, 3));
          maybe_gap();
          issue_cmd(OpPush, b, i == rlen - 1, 16'($urandom()));
          sent++;
        end
      end else if (kind <= 16) begin
        burst = $urandom_range(1, 4);
        repeat (burst) begin
          maybe_gap();
          lookup_random();
          sent++;
        end
      end else begin
        burst = $urandom_range(1, 5);
        repeat (burst) begin
          maybe_gap();
          issue_cmd(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                    1'($urandom_range(0, 1)), 16'($urandom()));
          sent++;
        end
      end
    end
  endtask

  initial begin
    len_reg     = ResetLen;
    roll_key    = '0;
    n_bases     = 0;
    read_halted = 1'b0;
    recent_key  = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_short_reads();
    test_len_extremes();
    test_unknown_base();
    test_len_change();
    test_repeat_key();
    test_random_traffic(RandItems);
    drain_counts();
    $display("Ran %0d commands: %0d counter lookups, %0d counted k-mers, %0d length writes",
             n_cmds, n_lookups, n_hits, n_len_writes);
    $display("Covered short reads, unknown bases, length limits, mid-read length change, "
             , "a heavily repeated k-mer and random read streams");
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: files.f
sv/kfc_pkg.sv
sv/kfc_ram.sv
sv/kfc_kmer_track.sv
sv/kfc_count_upd.sv
sv/kmer_frequency_counter.sv
tb/tb.sv
